FILE: rtl/mrpc_pkg.sv
// Shared types, constants and tables of the minimap rotate, project and clamp block.
`default_nettype none
package mrpc_pkg;

	localparam int COORD_BITS      = 24;
	localparam int ANGLE_W         = 16;
	localparam int RANGE_W         = 23;
	localparam int OUT_W           = 16;
	localparam int FRAC_BITS       = 16;
	localparam int ROT_W           = COORD_BITS + 20;
	localparam int ROT_STAGES_DEF  = 16;
	localparam int ATAN_N          = 24;

	localparam logic [29:0] GAIN_Q30 = 30'd652032874;

	localparam logic [31:0] ATAN_TURN32 [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] offset_x;
		logic signed [COORD_BITS-1:0] offset_y;
		logic [ANGLE_W-1:0]           yaw_angle;
	} in_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] map_x;
		logic signed [OUT_W-1:0] map_y;
		logic                    out_of_range;
	} out_word_t;

	// Pre-rotated offset and residual angle handed from the front to the rotator.
	typedef struct packed {
		logic signed [ROT_W-1:0] x;
		logic signed [ROT_W-1:0] y;
		logic signed [31:0]      r;
	} rot_job_t;

	// Gain-corrected magnitudes and signs of both output axes.
	typedef struct packed {
		logic [ROT_W-1:0] gx;
		logic [ROT_W-1:0] gy;
		logic             nx;
		logic             ny;
	} mag_t;

endpackage
`default_nettype wire

FILE: rtl/mrpc_front.sv
// Front stage: accepts input words, reduces the heading by quarter turns and pre-rotates.
`default_nettype none
module mrpc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  mrpc_pkg::in_word_t  in_word,
	input  wire                 q_full,
	output logic                push,
	output mrpc_pkg::rot_job_t  job
);
	import mrpc_pkg::*;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;
	localparam int EXT_W = ROT_W - COORD_BITS - FRAC_BITS;

	logic        front_v_q;
	rot_job_t    job_s1;
	rot_job_t    job_d;
	logic        load;
	logic [31:0] t;
	logic [31:0] tq;
	logic [31:0] u;
	logic [1:0]  quad;
	logic signed [ROT_W-1:0] x0;
	logic signed [ROT_W-1:0] y0;

	assign in_stall = front_v_q && q_full;
	assign load     = in_valid && !in_stall;
	assign push     = front_v_q && !q_full;
	assign job      = job_s1;

	always_comb begin
		t    = 32'd0 - {in_word.yaw_angle, 16'd0};
		tq   = t + 32'h2000_0000;
		quad = tq[31:30];
		u    = t - {quad, 30'd0};
		x0   = {{EXT_W{in_word.offset_x[COORD_BITS-1]}}, in_word.offset_x, 16'd0};
		y0   = {{EXT_W{in_word.offset_y[COORD_BITS-1]}}, in_word.offset_y, 16'd0};
		job_d.r = signed'(u);
		case (quad)
			QUAD_1: begin
				job_d.x = -y0;
				job_d.y = x0;
			end
			QUAD_2: begin
				job_d.x = -x0;
				job_d.y = -y0;
			end
			QUAD_3: begin
				job_d.x = y0;
				job_d.y = -x0;
			end
			QUAD_0: begin
				job_d.x = x0;
				job_d.y = y0;
			end
			default: begin
				job_d.x = x0;
				job_d.y = y0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_v_q <= 1'b0;
		end else if (load) begin
			front_v_q <= 1'b1;
		end else if (push) begin
			front_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s1 <= job_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mrpc_queue.sv
// Two-entry queue that decouples the front stage from the arithmetic pipeline.
`default_nettype none
module mrpc_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  mrpc_pkg::rot_job_t  wr_job,
	output logic                full,
	input  wire                 pop,
	output logic                not_empty,
	output mrpc_pkg::rot_job_t  rd_job
);
	import mrpc_pkg::*;

	rot_job_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mrpc_rotate.sv
// Pipelined CORDIC rotator followed by gain removal on the axis magnitudes.
`default_nettype none
module mrpc_rotate #(
	parameter int ROTATE_STAGES = mrpc_pkg::ROT_STAGES_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 adv,
	input  wire                 q_valid,
	input  mrpc_pkg::rot_job_t  q_job,
	output logic                pop,
	output logic                mag_valid,
	output mrpc_pkg::mag_t      mag
);
	import mrpc_pkg::*;

	localparam int DEPTH = ROTATE_STAGES + 4;
	localparam int MW    = ROT_W - 1;

	typedef struct packed {
		logic [MW-1:0] ma;
		logic [MW-1:0] mb;
		logic          nx;
		logic          ny;
	} abs_t;

	typedef struct packed {
		logic [48:0] hx;
		logic [48:0] hy;
		logic [53:0] lx;
		logic [53:0] ly;
		logic        nx;
		logic        ny;
	} mul_t;

	logic [DEPTH-1:0] vld_q;
	rot_job_t         cr_s [ROTATE_STAGES+1];
	abs_t             ab_s;
	mul_t             mu_s;
	mag_t             mag_s;
	abs_t             ab_d;
	mul_t             mu_d;
	mag_t             mag_d;

	assign pop       = adv && q_valid;
	assign mag_valid = vld_q[DEPTH-1];
	assign mag       = mag_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], q_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cr_s[0] <= q_job;
		end
	end

	for (genvar i = 0; i < ROTATE_STAGES; i++) begin : g_cord
		rot_job_t cur;
		rot_job_t nxt;
		logic signed [ROT_W-1:0] dx;
		logic signed [ROT_W-1:0] dy;

		always_comb begin
			cur = cr_s[i];
			dx  = cur.y >>> i;
			dy  = cur.x >>> i;
			nxt = cur;
			if (!cur.r[31]) begin
				nxt.x = cur.x - dx;
				nxt.y = cur.y + dy;
				nxt.r = cur.r - signed'(ATAN_TURN32[i]);
			end else begin
				nxt.x = cur.x + dx;
				nxt.y = cur.y - dy;
				nxt.r = cur.r + signed'(ATAN_TURN32[i]);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cr_s[i+1] <= nxt;
			end
		end
	end

	// The right axis (y) feeds map_x, the forward axis (x) feeds map_y.
	always_comb begin
		logic signed [ROT_W-1:0] ya;
		logic signed [ROT_W-1:0] xa;
		ya = cr_s[ROTATE_STAGES].y;
		xa = cr_s[ROTATE_STAGES].x;
		ab_d.nx = ya[ROT_W-1];
		ab_d.ny = xa[ROT_W-1];
		ab_d.ma = ab_d.nx ? MW'(-ya) : MW'(ya);
		ab_d.mb = ab_d.ny ? MW'(-xa) : MW'(xa);
	end

	always_comb begin
		mu_d.nx = ab_s.nx;
		mu_d.ny = ab_s.ny;
		mu_d.hx = 49'(ab_s.ma[MW-1:24]) * 49'(GAIN_Q30);
		mu_d.hy = 49'(ab_s.mb[MW-1:24]) * 49'(GAIN_Q30);
		mu_d.lx = 54'(ab_s.ma[23:0]) * 54'(GAIN_Q30);
		mu_d.ly = 54'(ab_s.mb[23:0]) * 54'(GAIN_Q30);
	end

	always_comb begin
		mag_d.nx = mu_s.nx;
		mag_d.ny = mu_s.ny;
		mag_d.gx = ROT_W'(mu_s.hx[48:6]) + ROT_W'(mu_s.lx[53:30]);
		mag_d.gy = ROT_W'(mu_s.hy[48:6]) + ROT_W'(mu_s.ly[53:30]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ab_s  <= ab_d;
			mu_s  <= mu_d;
			mag_s <= mag_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mrpc_clamp.sv
// Range division, disc test and radial normalization with square root, then saturation.
`default_nettype none
module mrpc_clamp (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          adv,
	input  wire [mrpc_pkg::RANGE_W-1:0]  map_range,
	input  wire                          mag_valid,
	input  mrpc_pkg::mag_t               mag,
	output logic                         out_valid,
	output mrpc_pkg::out_word_t          out_word
);
	import mrpc_pkg::*;

	localparam int RS_W  = RANGE_W + FRAC_BITS;
	localparam int REM_W = RS_W + 1;
	localparam int FQ    = 25;
	localparam int NSH   = 6;
	localparam int RTN   = 32;
	localparam int QDN   = 16;
	localparam int DEPTH = (FQ + 1) + 1 + (NSH + 1) + 1 + (RTN + 1) + QDN + 1;

	typedef struct packed {
		logic [REM_W-1:0] rx;
		logic [REM_W-1:0] ry;
		logic [FQ-1:0]    fx;
		logic [FQ-1:0]    fy;
		logic [ROT_W-1:0] gx;
		logic [ROT_W-1:0] gy;
		logic             nx;
		logic             ny;
		logic             zr;
		logic             inr;
	} dv_t;

	typedef struct packed {
		logic [2*FQ-1:0]  sx;
		logic [2*FQ-1:0]  sy;
		logic [FQ-1:0]    fx;
		logic [FQ-1:0]    fy;
		logic [ROT_W-1:0] gx;
		logic [ROT_W-1:0] gy;
		logic             nx;
		logic             ny;
		logic             zr;
		logic             inr;
	} sq_t;

	typedef struct packed {
		logic        zr;
		logic        in_disc;
		logic        nx;
		logic        ny;
		logic [16:0] mx;
		logic [16:0] my;
	} tag_t;

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		tag_t        tag;
	} nm_t;

	typedef struct packed {
		logic [30:0] ax;
		logic [30:0] ay;
		logic [61:0] sa;
		logic [61:0] sb;
		tag_t        tag;
	} sr_t;

	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] root;
		logic [63:0] vsh;
		logic [30:0] ax;
		logic [30:0] ay;
		tag_t        tag;
	} rt_t;

	typedef struct packed {
		logic [32:0] rx;
		logic [32:0] ry;
		logic [15:0] qx;
		logic [15:0] qy;
		logic [31:0] len;
		tag_t        tag;
	} qd_t;

	function automatic logic signed [15:0] sat_field(input logic [16:0] m, input logic neg);
		logic [16:0] ng;
		ng = 17'd0 - m;
		if (neg) begin
			return (m > 17'd32768) ? 16'sh8000 : signed'(ng[15:0]);
		end
		return (m > 17'd32767) ? 16'sh7fff : signed'(m[15:0]);
	endfunction

	logic [DEPTH-1:0] vld_q;
	dv_t              dv_s [FQ+1];
	sq_t              sq_s;
	nm_t              nm_s [NSH+1];
	sr_t              sr_s;
	rt_t              rt_s [RTN+1];
	qd_t              qd_s [QDN+1];
	out_word_t        out_word_q;

	logic [RS_W-1:0]  rs;
	logic [REM_W-1:0] rsx;
	dv_t              dv0_d;
	nm_t              nm0_d;
	sr_t              sr_d;
	rt_t              rt0_d;
	out_word_t        out_d;

	assign rs        = {map_range, {FRAC_BITS{1'b0}}};
	assign rsx       = {1'b0, rs};
	assign out_valid = vld_q[DEPTH-1];
	assign out_word  = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], mag_valid};
		end
	end

	// Inside the square |g| <= range the quotient g * 2^24 / range fits 25 bits.
	always_comb begin
		dv0_d.gx  = mag.gx;
		dv0_d.gy  = mag.gy;
		dv0_d.nx  = mag.nx;
		dv0_d.ny  = mag.ny;
		dv0_d.zr  = (map_range == '0);
		dv0_d.inr = (mag.gx <= ROT_W'(rs)) && (mag.gy <= ROT_W'(rs));
		dv0_d.rx  = dv0_d.inr ? mag.gx[REM_W-1:0] : '0;
		dv0_d.ry  = dv0_d.inr ? mag.gy[REM_W-1:0] : '0;
		dv0_d.fx  = '0;
		dv0_d.fy  = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0] <= dv0_d;
		end
	end

	for (genvar j = 1; j <= FQ; j++) begin : g_fdiv
		dv_t              cur;
		dv_t              nxt;
		logic [REM_W-1:0] tx;
		logic [REM_W-1:0] ty;
		logic             bx;
		logic             by;

		always_comb begin
			cur = dv_s[j-1];
			if (j == 1) begin
				tx = cur.rx;
				ty = cur.ry;
			end else begin
				tx = {cur.rx[REM_W-2:0], 1'b0};
				ty = {cur.ry[REM_W-2:0], 1'b0};
			end
			bx     = (tx >= rsx);
			by     = (ty >= rsx);
			nxt    = cur;
			nxt.rx = bx ? tx - rsx : tx;
			nxt.ry = by ? ty - rsx : ty;
			nxt.fx = {cur.fx[FQ-2:0], bx};
			nxt.fy = {cur.fy[FQ-2:0], by};
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[j] <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s.sx  <= (2*FQ)'(dv_s[FQ].fx) * (2*FQ)'(dv_s[FQ].fx);
			sq_s.sy  <= (2*FQ)'(dv_s[FQ].fy) * (2*FQ)'(dv_s[FQ].fy);
			sq_s.fx  <= dv_s[FQ].fx;
			sq_s.fy  <= dv_s[FQ].fy;
			sq_s.gx  <= dv_s[FQ].gx;
			sq_s.gy  <= dv_s[FQ].gy;
			sq_s.nx  <= dv_s[FQ].nx;
			sq_s.ny  <= dv_s[FQ].ny;
			sq_s.zr  <= dv_s[FQ].zr;
			sq_s.inr <= dv_s[FQ].inr;
		end
	end

	// A point exactly on the rim counts as inside.
	always_comb begin
		logic [2*FQ:0] len2;
		logic [FQ:0]   rx;
		logic [FQ:0]   ry;
		len2 = (2*FQ+1)'(sq_s.sx) + (2*FQ+1)'(sq_s.sy);
		rx   = {1'b0, sq_s.fx} + (FQ+1)'(256);
		ry   = {1'b0, sq_s.fy} + (FQ+1)'(256);
		nm0_d.tag.zr      = sq_s.zr;
		nm0_d.tag.in_disc = sq_s.inr && (len2 <= ((2*FQ+1)'(1) << 48));
		nm0_d.tag.nx      = sq_s.nx;
		nm0_d.tag.ny      = sq_s.ny;
		nm0_d.tag.mx      = rx[FQ:9];
		nm0_d.tag.my      = ry[FQ:9];
		nm0_d.a           = 64'(sq_s.gx);
		nm0_d.b           = 64'(sq_s.gy);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nm_s[0] <= nm0_d;
		end
	end

	// Left-justify both magnitudes together on the leading one of the larger.
	for (genvar k = 0; k < NSH; k++) begin : g_norm
		localparam int SH = 32 >> k;
		nm_t         cur;
		nm_t         nxt;
		logic [63:0] orw;

		always_comb begin
			cur = nm_s[k];
			orw = cur.a | cur.b;
			nxt = cur;
			if (orw[63 -: SH] == '0) begin
				nxt.a = cur.a << SH;
				nxt.b = cur.b << SH;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				nm_s[k+1] <= nxt;
			end
		end
	end

	always_comb begin
		sr_d.ax  = nm_s[NSH].a[63:33];
		sr_d.ay  = nm_s[NSH].b[63:33];
		sr_d.sa  = 62'(sr_d.ax) * 62'(sr_d.ax);
		sr_d.sb  = 62'(sr_d.ay) * 62'(sr_d.ay);
		sr_d.tag = nm_s[NSH].tag;
	end

	always_comb begin
		rt0_d.rem  = '0;
		rt0_d.root = '0;
		rt0_d.vsh  = 64'(sr_s.sa) + 64'(sr_s.sb);
		rt0_d.ax   = sr_s.ax;
		rt0_d.ay   = sr_s.ay;
		rt0_d.tag  = sr_s.tag;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sr_s    <= sr_d;
			rt_s[0] <= rt0_d;
		end
	end

	// Integer square root, two radicand bits per stage.
	for (genvar k = 0; k < RTN; k++) begin : g_sqrt
		rt_t         cur;
		rt_t         nxt;
		logic [34:0] r2;
		logic [34:0] trial;

		always_comb begin
			cur   = rt_s[k];
			r2    = {cur.rem[32:0], cur.vsh[63:62]};
			trial = {1'b0, cur.root, 2'b01};
			nxt   = cur;
			nxt.vsh = {cur.vsh[61:0], 2'b00};
			if (r2 >= trial) begin
				nxt.rem  = r2 - trial;
				nxt.root = {cur.root[30:0], 1'b1};
			end else begin
				nxt.rem  = r2;
				nxt.root = {cur.root[30:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_s[k+1] <= nxt;
			end
		end
	end

	// Each axis magnitude is at most the length, so a * 2^15 / len fits 16 bits.
	for (genvar j = 1; j <= QDN; j++) begin : g_qdiv
		qd_t         cur;
		qd_t         nxt;
		logic [32:0] tx;
		logic [32:0] ty;
		logic [32:0] lx;
		logic        bx;
		logic        by;

		always_comb begin
			if (j == 1) begin
				cur.rx  = 33'(rt_s[RTN].ax);
				cur.ry  = 33'(rt_s[RTN].ay);
				cur.qx  = '0;
				cur.qy  = '0;
				cur.len = rt_s[RTN].root;
				cur.tag = rt_s[RTN].tag;
				tx = cur.rx;
				ty = cur.ry;
			end else begin
				cur = qd_s[j-1];
				tx  = {cur.rx[31:0], 1'b0};
				ty  = {cur.ry[31:0], 1'b0};
			end
			lx     = {1'b0, cur.len};
			bx     = (tx >= lx);
			by     = (ty >= lx);
			nxt    = cur;
			nxt.rx = bx ? tx - lx : tx;
			nxt.ry = by ? ty - lx : ty;
			nxt.qx = {cur.qx[14:0], bx};
			nxt.qy = {cur.qy[14:0], by};
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				qd_s[j] <= nxt;
			end
		end
	end

	always_comb begin
		tag_t tg;
		tg = qd_s[QDN].tag;
		if (tg.zr) begin
			out_d.map_x        = '0;
			out_d.map_y        = '0;
			out_d.out_of_range = 1'b0;
		end else if (tg.in_disc) begin
			out_d.map_x        = sat_field(tg.mx, tg.nx);
			out_d.map_y        = sat_field(tg.my, tg.ny);
			out_d.out_of_range = 1'b0;
		end else begin
			out_d.map_x        = sat_field({1'b0, qd_s[QDN].qx}, tg.nx);
			out_d.map_y        = sat_field({1'b0, qd_s[QDN].qy}, tg.ny);
			out_d.out_of_range = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word_q <= out_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/minimap_rotate_project_clamp_top.sv
// An accepted word passes the front register, the queue, the rotator and the clamp pipeline.
// Throughput: one word per cycle while no output is held; all stages are fixed, no loop back.
// The rate is set by the single-step stages of the CORDIC, divider and square-root chains.
// Reset clears all valid flags, the queue and map_range; payload registers are not reset.
// With map_range at zero every word gives a zero point and a clear out_of_range flag.
`default_nettype none
module minimap_rotate_project_clamp_top #(
	parameter int ROTATE_STAGES = mrpc_pkg::ROT_STAGES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  mrpc_pkg::in_word_t           in_word,
	output logic                         out_valid,
	input  wire                          out_stall,
	output mrpc_pkg::out_word_t          out_word,
	input  wire                          cfg_we,
	input  wire [mrpc_pkg::RANGE_W-1:0]  cfg_wdata
);
	import mrpc_pkg::*;

	// The range register is to be written only while the block is idle; the block does not enforce it.
	logic [RANGE_W-1:0] map_range_q;

	// Front to queue.
	logic     push;
	logic     q_full;
	rot_job_t front_job;

	// Queue to rotator.
	logic     q_valid;
	logic     pop;
	rot_job_t q_job;

	// Rotator to clamp.
	logic     mag_valid;
	mag_t     mag;

	// The whole back pipeline moves together unless the output word is held.
	logic     adv;

	assign adv = !(out_valid && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_range_q <= '0;
		end else if (cfg_we) begin
			map_range_q <= cfg_wdata;
		end
	end

	// The front classifies the heading into a quarter turn and pre-rotates the offset.
	mrpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.q_full   (q_full),
		.push     (push),
		.job      (front_job)
	);

	// A short queue lets the front keep taking words while the back is stalled.
	mrpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (front_job),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.rd_job    (q_job)
	);

	// CORDIC rotation by the residual angle and removal of the CORDIC gain.
	mrpc_rotate #(
		.ROTATE_STAGES (ROTATE_STAGES)
	) u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.q_valid   (q_valid),
		.q_job     (q_job),
		.pop       (pop),
		.mag_valid (mag_valid),
		.mag       (mag)
	);

	// Scaling by the range, the unit-disc test and normalization of far points.
	mrpc_clamp u_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.map_range (map_range_q),
		.mag_valid (mag_valid),
		.mag       (mag),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

endmodule
`default_nettype wire
